@@ src/rfw_pkg.sv @@
// Shared types and constants for the frame reassembly window.
// Beat structs, event and reject codes, controller/datapath command and status groups.
package rfw_pkg;

    typedef struct packed {
        logic [15:0] received_bytes;
        logic [31:0] magic_word;
        logic        is_keyframe;
        logic [31:0] frame_number;
        logic [15:0] packet_index;
        logic [15:0] packet_total;
        logic [31:0] frame_bytes;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [2:0]  reject_reason;
        logic [3:0]  slot_index;
        logic [31:0] frame_id_out;
        logic [31:0] byte_offset;
        logic [31:0] byte_count;
        logic [15:0] width_out;
        logic [15:0] height_out;
        logic        last;
    } t_out_beat;

    localparam logic [1:0] EV_STORE   = 2'd0;
    localparam logic [1:0] EV_DELIVER = 2'd1;
    localparam logic [1:0] EV_DROP    = 2'd2;
    localparam logic [1:0] EV_REJECT  = 2'd3;

    localparam logic [2:0] RJ_NONE    = 3'd0;
    localparam logic [2:0] RJ_SHORT   = 3'd1;
    localparam logic [2:0] RJ_MAGIC   = 3'd2;
    localparam logic [2:0] RJ_AWAIT   = 3'd3;
    localparam logic [2:0] RJ_STALE   = 3'd4;
    localparam logic [2:0] RJ_HEADER  = 3'd5;
    localparam logic [2:0] RJ_DUP     = 3'd6;
    localparam logic [2:0] RJ_NOSLOT  = 3'd7;

    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_STRIDE  = 2'd1;
    localparam logic [1:0] CFG_HEADER  = 2'd2;
    localparam logic [1:0] CFG_BACKLOG = 2'd3;

    localparam logic [1:0] PEND_REJECT  = 2'd0;
    localparam logic [1:0] PEND_PACKET  = 2'd1;
    localparam logic [1:0] PEND_DELIVER = 2'd2;
    localparam logic [1:0] PEND_DROP    = 2'd3;

    typedef struct packed {
        logic       latch_in;
        logic       set_start;
        logic       scan_clr;
        logic       scan_step;
        logic       sel_match;
        logic       open_slot;
        logic       clr_step;
        logic       seen_upd;
        logic       rel_clr;
        logic       rel_step;
        logic       set_next_old;
        logic       free_old;
        logic       pend_load;
        logic [1:0] pend_sel;
        logic [2:0] reason;
        logic       flush;
        logic       flush_last;
    } t_cmd;

    typedef struct packed {
        logic rej_short;
        logic rej_magic;
        logic started;
        logic key;
        logic stale;
        logic idx_last;
        logic match_found;
        logic free_found;
        logic hdr_bad;
        logic clr_done;
        logic old_found;
        logic old_complete;
        logic old_over;
        logic out_free;
    } t_sts;

endpackage

@@ src/rfw_datapath.sv @@
// Datapath of the frame reassembly window: config registers, slot table, seen-map memory,
// scan registers, pending result and output register. Uses rfw_pkg.
module rfw_datapath #(
    parameter int SLOT_COUNT  = 16,
    parameter int MAX_PACKETS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  rfw_pkg::t_in_beat  i_in_data,
    input  logic               i_out_stall,
    input  rfw_pkg::t_cmd      i_cmd,
    output rfw_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output rfw_pkg::t_out_beat o_out_data
);
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int PW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int SEEN_DEPTH = SLOT_COUNT * MAX_PACKETS;
    localparam int AW = $clog2(SEEN_DEPTH);

    logic [31:0] r_magic;
    logic [15:0] r_stride;
    logic [7:0]  r_hdr;
    logic [3:0]  r_limit;

    rfw_pkg::t_in_beat r_in;
    logic        r_started;
    logic [31:0] r_next;

    logic [SLOT_COUNT-1:0] r_used;
    logic [31:0] r_sframe [SLOT_COUNT];
    logic [15:0] r_spkts  [SLOT_COUNT];
    logic [15:0] r_srecv  [SLOT_COUNT];
    logic [31:0] r_ssize  [SLOT_COUNT];
    logic [15:0] r_swid   [SLOT_COUNT];
    logic [15:0] r_shgt   [SLOT_COUNT];

    logic [SW-1:0] r_idx, r_midx, r_fidx, r_oidx, r_cur;
    logic          r_mfound, r_ffound, r_ofound;
    logic [31:0]   r_oframe;
    logic [CW-1:0] r_ucnt;
    logic [PW-1:0] r_clr;
    logic [31:0]   r_off;

    logic          r_seen_mem [SEEN_DEPTH];
    logic          r_seen_q;

    rfw_pkg::t_out_beat r_pend, r_out;
    rfw_pkg::t_out_beat n_pend, n_out;
    logic               r_ovalid;

    logic [AW-1:0] base, raddr, waddr;
    logic          seen_we, seen_wd;
    logic [15:0]   payload;
    logic          pkt_ok;

    assign payload = r_in.received_bytes - {8'd0, r_hdr};
    assign base    = AW'(r_cur) * AW'(MAX_PACKETS);
    assign raddr   = base + AW'(r_in.packet_index[PW-1:0]);
    assign pkt_ok  = (r_in.packet_index < r_spkts[r_cur])
                  && (32'(r_in.packet_index) < 32'(MAX_PACKETS))
                  && !r_seen_q
                  && (({1'b0, r_off} + 33'(payload)) <= {1'b0, r_ssize[r_cur]});

    always_comb begin
        seen_we = 1'b0;
        seen_wd = 1'b0;
        waddr   = raddr;
        if (i_cmd.clr_step) begin
            seen_we = 1'b1;
            waddr   = base + AW'(r_clr);
        end else if (i_cmd.seen_upd && pkt_ok) begin
            seen_we = 1'b1;
            seen_wd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seen_we) begin
            r_seen_mem[waddr] <= seen_wd;
        end
        r_seen_q <= r_seen_mem[raddr];
    end

    // Build the pending beat and the outgoing beat.
    always_comb begin
        n_pend              = '0;
        n_pend.frame_id_out = r_in.frame_number;
        unique case (i_cmd.pend_sel)
            rfw_pkg::PEND_REJECT: begin
                n_pend.event_kind    = rfw_pkg::EV_REJECT;
                n_pend.reject_reason = i_cmd.reason;
            end
            rfw_pkg::PEND_PACKET: begin
                n_pend.slot_index = 4'(r_cur);
                if (pkt_ok) begin
                    n_pend.event_kind  = rfw_pkg::EV_STORE;
                    n_pend.byte_offset = r_off;
                    n_pend.byte_count  = 32'(payload);
                end else begin
                    n_pend.event_kind    = rfw_pkg::EV_REJECT;
                    n_pend.reject_reason = rfw_pkg::RJ_DUP;
                end
            end
            rfw_pkg::PEND_DELIVER: begin
                n_pend.event_kind   = rfw_pkg::EV_DELIVER;
                n_pend.slot_index   = 4'(r_oidx);
                n_pend.frame_id_out = r_oframe;
                n_pend.byte_count   = r_ssize[r_oidx];
                n_pend.width_out    = r_swid[r_oidx];
                n_pend.height_out   = r_shgt[r_oidx];
            end
            rfw_pkg::PEND_DROP: begin
                n_pend.event_kind   = rfw_pkg::EV_DROP;
                n_pend.slot_index   = 4'(r_oidx);
                n_pend.frame_id_out = r_oframe;
            end
            default: ;
        endcase
        n_out      = r_pend;
        n_out.last = i_cmd.flush_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= 32'd0;
            r_stride  <= 16'd1400;
            r_hdr     <= 8'd28;
            r_limit   <= 4'd12;
            r_started <= 1'b0;
            r_next    <= 32'd0;
            r_used    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rfw_pkg::CFG_MAGIC:   r_magic  <= i_cfg_data;
                    rfw_pkg::CFG_STRIDE:  r_stride <= i_cfg_data[15:0];
                    rfw_pkg::CFG_HEADER:  r_hdr    <= i_cfg_data[7:0];
                    rfw_pkg::CFG_BACKLOG: r_limit  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.set_start) begin
                r_started <= 1'b1;
                r_next    <= r_in.frame_number;
            end
            if (i_cmd.open_slot) begin
                r_used[r_fidx] <= 1'b1;
            end
            if (i_cmd.set_next_old) begin
                r_next <= r_oframe;
            end
            if (i_cmd.free_old) begin
                r_next         <= r_oframe + 32'd1;
                r_used[r_oidx] <= 1'b0;
            end
            if (i_cmd.flush) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_off <= {16'd0, r_in.packet_index} * {16'd0, r_stride};
        if (i_cmd.latch_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.scan_clr || i_cmd.rel_clr) begin
            r_idx    <= '0;
            r_mfound <= 1'b0;
            r_ffound <= 1'b0;
            r_ofound <= 1'b0;
            r_ucnt   <= '0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + SW'(1);
            if (r_used[r_idx] && r_sframe[r_idx] == r_in.frame_number && !r_mfound) begin
                r_mfound <= 1'b1;
                r_midx   <= r_idx;
            end
            if (!r_used[r_idx] && !r_ffound) begin
                r_ffound <= 1'b1;
                r_fidx   <= r_idx;
            end
        end
        if (i_cmd.rel_step) begin
            r_idx <= r_idx + SW'(1);
            if (r_used[r_idx]) begin
                r_ucnt <= r_ucnt + CW'(1);
                if (!r_ofound || r_sframe[r_idx] < r_oframe) begin
                    r_ofound <= 1'b1;
                    r_oidx   <= r_idx;
                    r_oframe <= r_sframe[r_idx];
                end
            end
        end
        if (i_cmd.sel_match) begin
            r_cur <= r_midx;
        end
        if (i_cmd.open_slot) begin
            r_cur            <= r_fidx;
            r_clr            <= '0;
            r_sframe[r_fidx] <= r_in.frame_number;
            r_spkts[r_fidx]  <= r_in.packet_total;
            r_srecv[r_fidx]  <= 16'd0;
            r_ssize[r_fidx]  <= r_in.frame_bytes;
            r_swid[r_fidx]   <= r_in.frame_width;
            r_shgt[r_fidx]   <= r_in.frame_height;
        end
        if (i_cmd.clr_step) begin
            r_clr <= r_clr + PW'(1);
        end
        if (i_cmd.seen_upd && pkt_ok) begin
            r_srecv[r_cur] <= r_srecv[r_cur] + 16'd1;
        end
        if (i_cmd.pend_load) begin
            r_pend <= n_pend;
        end
        if (i_cmd.flush) begin
            r_out <= n_out;
        end
    end

    assign o_sts.rej_short    = r_in.received_bytes < {8'd0, r_hdr};
    assign o_sts.rej_magic    = r_in.magic_word != r_magic;
    assign o_sts.started      = r_started;
    assign o_sts.key          = r_in.is_keyframe;
    assign o_sts.stale        = r_in.frame_number < r_next;
    assign o_sts.idx_last     = r_idx == SW'(SLOT_COUNT - 1);
    assign o_sts.match_found  = r_mfound;
    assign o_sts.free_found   = r_ffound;
    assign o_sts.hdr_bad      = (r_in.packet_total == 16'd0) || (r_in.frame_bytes == 32'd0)
                             || (32'(r_in.packet_total) > 32'(MAX_PACKETS));
    assign o_sts.clr_done     = r_clr == PW'(MAX_PACKETS - 1);
    assign o_sts.old_found    = r_ofound;
    assign o_sts.old_complete = r_srecv[r_oidx] == r_spkts[r_oidx];
    assign o_sts.old_over     = 8'(r_ucnt) > 8'(r_limit);
    assign o_sts.out_free     = !r_ovalid || !i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

@@ src/rfw_ctrl.sv @@
// Controller of the frame reassembly window: sequences checks, slot search, seen-map
// clear, store decision and the release loop. Uses rfw_pkg command and status structs.
module rfw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rfw_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output rfw_pkg::t_cmd o_cmd
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_STALE = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_SDEC  = 4'd4;
    localparam logic [3:0] ST_CLEAR = 4'd5;
    localparam logic [3:0] ST_SRD   = 4'd6;
    localparam logic [3:0] ST_SCHK  = 4'd7;
    localparam logic [3:0] ST_RSCAN = 4'd8;
    localparam logic [3:0] ST_RDEC  = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == ST_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                o_cmd.pend_sel = rfw_pkg::PEND_REJECT;
                priority if (i_sts.rej_short) begin
                    o_cmd.pend_load = 1'b1;
                    o_cmd.reason = rfw_pkg::RJ_SHORT;
                    n_state = ST_FIN;
                end else if (i_sts.rej_magic) begin
                    o_cmd.pend_load = 1'b1;
                    o_cmd.reason = rfw_pkg::RJ_MAGIC;
                    n_state = ST_FIN;
                end else if (!i_sts.started && !i_sts.key) begin
                    o_cmd.pend_load = 1'b1;
                    o_cmd.reason = rfw_pkg::RJ_AWAIT;
                    n_state = ST_FIN;
                end else begin
                    o_cmd.set_start = !i_sts.started;
                    n_state = ST_STALE;
                end
            end
            ST_STALE: begin
                o_cmd.pend_sel = rfw_pkg::PEND_REJECT;
                o_cmd.reason = rfw_pkg::RJ_STALE;
                if (i_sts.stale) begin
                    o_cmd.pend_load = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_SDEC;
                end
            end
            ST_SDEC: begin
                o_cmd.pend_sel = rfw_pkg::PEND_REJECT;
                priority if (i_sts.match_found) begin
                    o_cmd.sel_match = 1'b1;
                    n_state = ST_SRD;
                end else if (i_sts.hdr_bad) begin
                    o_cmd.pend_load = 1'b1;
                    o_cmd.reason = rfw_pkg::RJ_HEADER;
                    n_state = ST_FIN;
                end else if (!i_sts.free_found) begin
                    o_cmd.pend_load = 1'b1;
                    o_cmd.reason = rfw_pkg::RJ_NOSLOT;
                    n_state = ST_FIN;
                end else begin
                    o_cmd.open_slot = 1'b1;
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_SRD;
                end
            end
            ST_SRD: begin
                // seen bit read lands next cycle
                n_state = ST_SCHK;
            end
            ST_SCHK: begin
                o_cmd.seen_upd = 1'b1;
                o_cmd.pend_load = 1'b1;
                o_cmd.pend_sel = rfw_pkg::PEND_PACKET;
                o_cmd.rel_clr = 1'b1;
                n_state = ST_RSCAN;
            end
            ST_RSCAN: begin
                o_cmd.rel_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_RDEC;
                end
            end
            ST_RDEC: begin
                priority if (!i_sts.old_found) begin
                    n_state = ST_FIN;
                end else if (i_sts.old_complete || i_sts.old_over) begin
                    // push the previous beat out before the release event takes its place
                    if (i_sts.out_free) begin
                        o_cmd.flush = 1'b1;
                        o_cmd.pend_load = 1'b1;
                        o_cmd.pend_sel = i_sts.old_complete ? rfw_pkg::PEND_DELIVER
                                                            : rfw_pkg::PEND_DROP;
                        o_cmd.free_old = 1'b1;
                        o_cmd.rel_clr = 1'b1;
                        n_state = ST_RSCAN;
                    end
                end else begin
                    o_cmd.set_next_old = 1'b1;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    o_cmd.flush_last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_flush_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |-> i_sts.out_free) else $error("beat loaded into busy output");
    a_open_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.open_slot |-> i_sts.free_found && !i_sts.match_found)
        else $error("slot opened without a free slot");
    a_schk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCHK) |-> ($past(r_state) == ST_SRD))
        else $error("seen check without read cycle");

endmodule

@@ src/udp_frame_reassembly_window_top.sv @@
// Top level of the frame reassembly window: controller plus datapath.
// Depends on rfw_pkg, rfw_ctrl and rfw_datapath.
//
// One packet descriptor is taken at a time. A packet rejected on length, magic or keyframe
// goes from the check state straight to the finish state; a stale one passes the stale check
// first. A packet for a known frame runs the slot search, then the oldest-frame search, and
// that search again per released frame; both walk the slot table one slot a cycle. A packet
// that opens a slot also clears the frame's seen-map row in the memory one bit a cycle.
// Results leave through an output register; each release beat waits for the previous beat
// to leave.
module udp_frame_reassembly_window_top #(
    parameter int SLOT_COUNT  = 16,
    parameter int MAX_PACKETS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rfw_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rfw_pkg::t_out_beat o_out_data
);
    rfw_pkg::t_cmd cmd;
    rfw_pkg::t_sts sts;
    logic          in_ready;

    assign o_in_stall = !in_ready;

    rfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    rfw_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .MAX_PACKETS (MAX_PACKETS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ dv/udp_frame_reassembly_window_top_tb.sv @@
// Self-checking testbench for udp_frame_reassembly_window_top.
// Depends on rfw_pkg and the block's RTL; a scoreboard class predicts every result beat.
module udp_frame_reassembly_window_top_tb;

    localparam int SLOTS = 16;
    localparam int MAXPK = 256;
    localparam int DRAIN = 1200;

    class reassembly_scoreboard;
        logic [31:0] magic;
        logic [15:0] stride;
        logic [7:0]  hdr;
        logic [3:0]  backlog;
        bit          started;
        logic [31:0] next_exp;
        bit          used[SLOTS];
        logic [31:0] frame[SLOTS];
        logic [15:0] packets[SLOTS];
        logic [15:0] rcvd[SLOTS];
        logic [31:0] fsize[SLOTS];
        logic [31:0] dims[SLOTS];
        bit [MAXPK-1:0] seen[SLOTS];
        rfw_pkg::t_out_beat events_q[$];
        int          errors;

        function new();
            magic = 0; stride = 1400; hdr = 28; backlog = 12;
            started = 0; next_exp = 0; errors = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                rfw_pkg::CFG_MAGIC:   magic = d;
                rfw_pkg::CFG_STRIDE:  stride = d[15:0];
                rfw_pkg::CFG_HEADER:  hdr = d[7:0];
                rfw_pkg::CFG_BACKLOG: backlog = d[3:0];
                default: ;
            endcase
        endfunction

        function void push_event(logic [1:0] kind, logic [2:0] why, int slot, logic [31:0] fr,
                                 logic [31:0] off, logic [31:0] cnt, logic [15:0] w,
                                 logic [15:0] h, bit fin);
            rfw_pkg::t_out_beat r;
            r.event_kind = kind; r.reject_reason = why; r.slot_index = slot[3:0];
            r.frame_id_out = fr; r.byte_offset = off; r.byte_count = cnt;
            r.width_out = w; r.height_out = h; r.last = fin;
            events_q.push_back(r);
        endfunction

        // Predict the beats one accepted descriptor causes.
        function void note_packet(rfw_pkg::t_in_beat b);
            logic [31:0] payload;
            logic [63:0] off;
            int slot, old, nused;
            slot = -1;
            if (b.received_bytes < hdr) begin
                push_event(rfw_pkg::EV_REJECT, rfw_pkg::RJ_SHORT, 0, b.frame_number,
                           0, 0, 0, 0, 1);
                return;
            end
            if (b.magic_word != magic) begin
                push_event(rfw_pkg::EV_REJECT, rfw_pkg::RJ_MAGIC, 0, b.frame_number,
                           0, 0, 0, 0, 1);
                return;
            end
            if (!started) begin
                if (!b.is_keyframe) begin
                    push_event(rfw_pkg::EV_REJECT, rfw_pkg::RJ_AWAIT, 0, b.frame_number,
                               0, 0, 0, 0, 1);
                    return;
                end
                next_exp = b.frame_number;
                started = 1;
            end
            if (b.frame_number < next_exp) begin
                push_event(rfw_pkg::EV_REJECT, rfw_pkg::RJ_STALE, 0, b.frame_number,
                           0, 0, 0, 0, 1);
                return;
            end
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && used[i] && frame[i] == b.frame_number) slot = i;
            if (slot < 0) begin
                if (b.packet_total == 0 || b.frame_bytes == 0 || b.packet_total > MAXPK) begin
                    push_event(rfw_pkg::EV_REJECT, rfw_pkg::RJ_HEADER, 0, b.frame_number,
                               0, 0, 0, 0, 1);
                    return;
                end
                for (int i = 0; i < SLOTS; i++)
                    if (slot < 0 && !used[i]) slot = i;
                if (slot < 0) begin
                    push_event(rfw_pkg::EV_REJECT, rfw_pkg::RJ_NOSLOT, 0, b.frame_number,
                               0, 0, 0, 0, 1);
                    return;
                end
                used[slot] = 1; frame[slot] = b.frame_number;
                packets[slot] = b.packet_total; rcvd[slot] = 0;
                fsize[slot] = b.frame_bytes; dims[slot] = {b.frame_width, b.frame_height};
                seen[slot] = '0;
            end
            payload = 32'(b.received_bytes) - 32'(hdr);
            off = 64'(b.packet_index) * 64'(stride);
            if (b.packet_index < packets[slot] && b.packet_index < MAXPK
                && !seen[slot][b.packet_index[7:0]] && off + 64'(payload) <= 64'(fsize[slot])) begin
                seen[slot][b.packet_index[7:0]] = 1;
                rcvd[slot] = rcvd[slot] + 16'd1;
                push_event(rfw_pkg::EV_STORE, rfw_pkg::RJ_NONE, slot, b.frame_number,
                           off[31:0], payload, 0, 0, 0);
            end else begin
                push_event(rfw_pkg::EV_REJECT, rfw_pkg::RJ_DUP, slot, b.frame_number,
                           0, 0, 0, 0, 0);
            end
            // Release the oldest frames in order.
            forever begin
                old = -1; nused = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (used[i]) begin
                        nused++;
                        if (old < 0 || frame[i] < frame[old]) old = i;
                    end
                end
                if (old < 0) break;
                next_exp = frame[old];
                if (rcvd[old] == packets[old])
                    push_event(rfw_pkg::EV_DELIVER, rfw_pkg::RJ_NONE, old, frame[old], 0,
                               fsize[old], dims[old][31:16], dims[old][15:0], 0);
                else if (nused > backlog)
                    push_event(rfw_pkg::EV_DROP, rfw_pkg::RJ_NONE, old, frame[old],
                               0, 0, 0, 0, 0);
                else
                    break;
                next_exp = frame[old] + 32'd1;
                used[old] = 0;
            end
            events_q[events_q.size() - 1].last = 1;
        endfunction

        function void check_event(rfw_pkg::t_out_beat act);
            rfw_pkg::t_out_beat exp_b;
            if (events_q.size() == 0) begin
                $display("%0t: unexpected beat %p", $time, act);
                errors++;
                return;
            end
            exp_b = events_q.pop_front();
            if (act.event_kind !== exp_b.event_kind || act.reject_reason !== exp_b.reject_reason
                || act.slot_index !== exp_b.slot_index || act.frame_id_out !== exp_b.frame_id_out
                || act.byte_offset !== exp_b.byte_offset || act.byte_count !== exp_b.byte_count
                || act.width_out !== exp_b.width_out || act.height_out !== exp_b.height_out
                || act.last !== exp_b.last) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp_b, act);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_idx = rfw_pkg::CFG_MAGIC;
    logic [31:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    rfw_pkg::t_in_beat  in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    rfw_pkg::t_out_beat out_data;

    reassembly_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;

    udp_frame_reassembly_window_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Receiver: random stall, or a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_stall = 1;
            hold_cycles--;
        end else begin
            out_stall = ($urandom_range(0, 99) < recv_idle);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && out_valid && !out_stall) sb.check_event(out_data);

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        cfg_we = 1; cfg_idx = idx; cfg_data = d;
        @(negedge i_clk);
        cfg_we = 0;
        sb.write_reg(idx, d);
    endtask

    task automatic send(rfw_pkg::t_in_beat b);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid = 0;
            @(negedge i_clk);
        end
        in_valid = 1;
        in_data = b;
        do @(posedge i_clk); while (in_stall);
        sb.note_packet(b);
        @(negedge i_clk);
        in_valid = 0;
    endtask

    task automatic wait_idle();
        while (sb.events_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    function automatic rfw_pkg::t_in_beat pkt(logic [31:0] fr, logic [15:0] idx,
                                              logic [15:0] tot, logic [31:0] fbytes,
                                              logic [15:0] pay, bit key);
        rfw_pkg::t_in_beat b;
        b.received_bytes = 16'(sb.hdr) + pay;
        b.magic_word = sb.magic;
        b.is_keyframe = key;
        b.frame_number = fr;
        b.packet_index = idx;
        b.packet_total = tot;
        b.frame_bytes = fbytes;
        b.frame_width = 16'($urandom);
        b.frame_height = 16'($urandom);
        return b;
    endfunction

    function automatic rfw_pkg::t_in_beat random_item();
        rfw_pkg::t_in_beat b;
        logic [31:0] fr;
        logic [15:0] tot, pay;
        logic [223:0] rnd;
        int pick;
        pick = $urandom_range(0, 99);
        fr = sb.next_exp + $urandom_range(0, 3);
        tot = 16'(fr[1:0]) + 16'd1;
        pay = (32'(sb.stride) + sb.hdr > 65535) ? 16'(65535 - sb.hdr) : sb.stride;
        if ($urandom_range(0, 3) == 0) pay = 16'($urandom_range(0, pay));
        b = pkt(fr, 16'($urandom_range(0, tot - 1)), tot, 32'(tot) * sb.stride, pay,
                1'($urandom));
        if (pick < 10) begin
            rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            b = rnd[$bits(rfw_pkg::t_in_beat)-1:0];
        end else if (pick < 14) begin
            b.packet_index = 16'($urandom_range(0, tot + 2));
        end else if (pick < 17) begin
            b.frame_number = sb.next_exp - 32'd1;
        end else if (pick < 19) begin
            b.received_bytes = 16'($urandom_range(0, sb.hdr));
        end else if (pick < 20) begin
            b.frame_number = sb.next_exp + 32'd8;
            b.packet_total = 16'($urandom_range(0, 300));
            b.frame_bytes = $urandom_range(0, 1) ? 32'd0 : $urandom;
        end
        return b;
    endfunction

    initial begin
        rfw_pkg::t_in_beat b;
        logic [31:0] f0;
        int count;
        count = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: every reject reason but no-slot, delivery, stale and frame number wrap.
        write_reg(rfw_pkg::CFG_MAGIC, 32'h5A5A_0001);
        write_reg(rfw_pkg::CFG_STRIDE, 32'd1400);
        write_reg(rfw_pkg::CFG_HEADER, 32'd28);
        write_reg(rfw_pkg::CFG_BACKLOG, 32'd12);
        f0 = 32'hFFFF_FFFD;
        b = pkt(f0, 0, 2, 2800, 1400, 1); b.received_bytes = 0; send(b);
        b = pkt(f0, 0, 2, 2800, 1400, 1); b.magic_word = ~b.magic_word; send(b);
        send(pkt(f0, 0, 2, 2800, 1400, 0));
        send(pkt(f0, 0, 0, 2800, 1400, 1));
        send(pkt(f0, 0, 2, 0, 1400, 1));
        send(pkt(f0, 0, 257, 2800, 1400, 1));
        send(pkt(f0, 0, 2, 2800, 1400, 1));
        send(pkt(f0, 0, 2, 2800, 1400, 0));
        send(pkt(f0, 5, 2, 2800, 1400, 0));
        send(pkt(f0 + 1, 0, 1, 10, 100, 0));
        send(pkt(f0, 1, 2, 2800, 1400, 0));
        send(pkt(f0, 0, 2, 2800, 1400, 0));
        send(pkt(f0 + 1, 0, 1, 10, 10, 0));
        b = pkt(32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 16'(65535 - 28), 1);
        b.frame_width = 16'hFFFF; b.frame_height = 16'hFFFF; send(b);
        b = pkt(0, 0, 1, 1, 0, 0); b.frame_width = 0; b.frame_height = 0; send(b);

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(rfw_pkg::CFG_BACKLOG, 32'd1);
                    write_reg(rfw_pkg::CFG_STRIDE, 32'd1);
                end
                1: begin
                    write_reg(rfw_pkg::CFG_MAGIC, 32'hFFFF_FFFF);
                    write_reg(rfw_pkg::CFG_STRIDE, 32'h0000_FFFF);
                    write_reg(rfw_pkg::CFG_HEADER, 32'd255);
                    write_reg(rfw_pkg::CFG_BACKLOG, 32'd14);
                end
                2: begin
                    write_reg(rfw_pkg::CFG_MAGIC, 32'd0);
                    write_reg(rfw_pkg::CFG_HEADER, 32'd0);
                    write_reg(rfw_pkg::CFG_STRIDE, 32'd700);
                    write_reg(rfw_pkg::CFG_BACKLOG, 32'd3);
                end
                default: begin
                    write_reg(rfw_pkg::CFG_MAGIC, $urandom);
                    write_reg(rfw_pkg::CFG_STRIDE, $urandom_range(1, 3000));
                    write_reg(rfw_pkg::CFG_HEADER, $urandom_range(0, 255));
                    write_reg(rfw_pkg::CFG_BACKLOG, $urandom_range(1, 14));
                end
            endcase
            for (int k = 0; k < 62; k++) begin
                if (count < 85) begin
                    send_idle = 23; recv_idle = 47;
                end else if (count < 170) begin
                    send_idle = 47; recv_idle = 23;
                end else begin
                    send_idle = 0; recv_idle = 0;
                end
                // Hold the receiver off so the block fills and stalls its input.
                if (ph == 1 && k == 20) hold_cycles = 3000;
                send(random_item());
                count++;
            end
        end

        while (sb.events_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (sb.errors == 0 && sb.events_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ udp_frame_reassembly_window_top.f @@
src/rfw_pkg.sv
src/rfw_datapath.sv
src/rfw_ctrl.sv
src/udp_frame_reassembly_window_top.sv
dv/udp_frame_reassembly_window_top_tb.sv
